// ===== design/rational_arith_gcd_reduce_assert.svh =====
// Assertion macros for the rational gcd reduction block.
// Included by the modules that carry concurrent checks.
`ifndef RATIONAL_ARITH_GCD_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_GCD_REDUCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RAG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define RAG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAG_ASSERT(lbl, clk, rst, prop)
`define RAG_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== design/rag_pkg.sv =====
// Shared types and constants for the rational gcd reduction block.
// No dependencies.
`timescale 1ns / 1ps
package rag_pkg;
  localparam int RES_W = 33;
  localparam int WIDE_W = 66;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVD,
    ST_DIVN,
    ST_OUT
  } be_state_t;

  // Entry passed from front to back: raw fraction and gcd seeds.
  typedef struct packed {
    logic                     err;
    logic                     swap;
    logic signed [WIDE_W-1:0] n;
    logic signed [WIDE_W-1:0] d;
  } job_t;
endpackage

// ===== design/rational_arith_gcd_reduce.sv =====
// Rational add/sub/mul/div of two signed fractions with gcd reduction. One
// transaction at a time in the back end, all through one shared bit-serial
// divider: each Euclid remainder step issues a division and runs its bit
// steps, then the two quotient passes divide the denominator and then the
// numerator by the gcd, and the result waits in the output state. Euclid
// needs up to roughly 47 remainder steps on 33-bit values. Results with a zero
// input denominator still run the gcd loop but skip the quotient passes. A
// two-entry queue lets the front take the next transaction meanwhile, while
// there is room.
`timescale 1ns / 1ps
module rational_arith_gcd_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [32:0]              res_num,
  output logic signed [32:0]              res_den,
  output logic                            status
);
  rag_pkg::job_t fj, qj;
  logic fv, fs, qv, qs;

  rag_front #(.OW(OPERAND_WIDTH)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .opcode, .a_num, .a_den,
    .b_num, .b_den, .job_valid(fv), .job_stall(fs), .job(fj)
  );
  rag_queue u_queue (
    .clk, .rst, .in_valid(fv), .in_stall(fs), .in_job(fj),
    .out_valid(qv), .out_stall(qs), .out_job(qj)
  );
  rag_back u_back (
    .clk, .rst, .job_valid(qv), .job_stall(qs), .job(qj),
    .valid(out_valid), .stall(out_stall), .res_num, .res_den, .status
  );
endmodule

// ===== design/rag_front.sv =====
// Front end: accepts transactions, forms the raw fraction from registered operands.
// Depends on rag_pkg.
`timescale 1ns / 1ps
module rag_front #(
  parameter int OW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic [1:0]           opcode,
  input  logic signed [OW-1:0] a_num,
  input  logic signed [OW-1:0] a_den,
  input  logic signed [OW-1:0] b_num,
  input  logic signed [OW-1:0] b_den,
  output logic                 job_valid,
  input  logic                 job_stall,
  output rag_pkg::job_t        job
);
  localparam int PW = 2 * OW + 1;

  logic                 busy;
  logic [1:0]           op;
  logic signed [OW-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] p, q, r;
  logic                 ok;

  assign stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy && valid) begin
      busy <= 1'b1;
    end else if (busy && !job_stall) begin
      busy <= 1'b0;
    end
    if (!busy && valid) begin
      op <= opcode;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
  end

  always_comb begin
    ok = (ad != '0) && (bd != '0);
    p = '0;
    q = '0;
    r = '0;
    job.err = !ok;
    job.swap = 1'b0;
    case (rag_pkg::op_t'(op))
      rag_pkg::OP_ADD, rag_pkg::OP_SUB: begin
        job.swap = 1'b1;
        if (ad != bd) begin
          p = PW'(an) * PW'(bd);
          q = PW'(bn) * PW'(ad);
          r = PW'(ad) * PW'(bd);
        end else begin
          p = PW'(an);
          q = PW'(bn);
          r = PW'(ad);
        end
        if (op == rag_pkg::OP_SUB) p = p - q;
        else p = p + q;
      end
      rag_pkg::OP_MUL: begin
        p = PW'(an) * PW'(bn);
        r = PW'(ad) * PW'(bd);
      end
      default: begin
        p = PW'(an) * PW'(bd);
        r = PW'(ad) * PW'(bn);
      end
    endcase
    job.n = rag_pkg::WIDE_W'(p);
    job.d = rag_pkg::WIDE_W'(r);
  end

  assign job_valid = busy;
endmodule

// ===== design/rag_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on rag_pkg and the assertion header.
`timescale 1ns / 1ps
`include "rational_arith_gcd_reduce_assert.svh"
module rag_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rag_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_stall,
  output rag_pkg::job_t out_job
);
  rag_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_stall = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;
  assign out_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= in_job;
  end

  `RAG_ASSERT(a_cnt_max, clk, rst, cnt <= 2'd2)
  `RAG_ASSERT(a_ptr_eq, clk, rst, (cnt == 2'd0 || cnt == 2'd2) |-> (wp == rp))
  `RAG_ASSERT(a_ptr_ne, clk, rst, (cnt == 2'd1) |-> (wp != rp))
endmodule

// ===== design/rag_back.sv =====
// Back end: Euclid gcd by shared restoring divider, then two quotient passes.
// Depends on rag_pkg and the assertion header.
`timescale 1ns / 1ps
`include "rational_arith_gcd_reduce_assert.svh"
module rag_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  output logic                             job_stall,
  input  rag_pkg::job_t                    job,
  output logic                             valid,
  input  logic                             stall,
  output logic signed [rag_pkg::RES_W-1:0] res_num,
  output logic signed [rag_pkg::RES_W-1:0] res_den,
  output logic                             status
);
  localparam int W = rag_pkg::WIDE_W;
  localparam int CW = $clog2(W + 1);

  rag_pkg::be_state_t state, state_next;
  logic signed [W-1:0] x, y, n, d, g;
  logic        [W-1:0] rem, quo, dvs;
  logic                qneg, rneg, err;
  logic        [CW-1:0] cnt;
  logic                div_busy;
  logic        [W:0]   trial;
  logic        [W-1:0] rem_sh;
  logic                ovalid;

  assign job_stall = (state != rag_pkg::ST_IDLE);
  assign valid = ovalid;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  always_comb begin
    rem_sh = {rem[W-2:0], quo[W-1]};
    trial = {1'b0, rem_sh} - {1'b0, dvs};
  end

  always_comb begin
    state_next = state;
    case (state)
      rag_pkg::ST_IDLE: if (job_valid) state_next = rag_pkg::ST_GCD;
      rag_pkg::ST_GCD: if (!div_busy && y == '0) state_next = rag_pkg::ST_DIVD;
      rag_pkg::ST_DIVD: if (!div_busy && cnt == CW'(W)) state_next = rag_pkg::ST_DIVN;
      rag_pkg::ST_DIVN: if (!div_busy && cnt == CW'(W)) state_next = rag_pkg::ST_OUT;
      rag_pkg::ST_OUT: if (!ovalid) state_next = rag_pkg::ST_IDLE;
      default: state_next = rag_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rag_pkg::ST_IDLE;
      div_busy <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ovalid && !stall) ovalid <= 1'b0;
      case (state)
        rag_pkg::ST_IDLE: begin
          if (job_valid) begin
            n <= job.n;
            d <= job.d;
            err <= job.err;
            x <= job.swap ? job.d : job.n;
            y <= job.swap ? job.n : job.d;
            div_busy <= 1'b0;
          end
        end
        rag_pkg::ST_GCD: begin
          if (!div_busy) begin
            if (y != '0) begin
              div_busy <= 1'b1;
              cnt <= '0;
              rem <= '0;
              quo <= mag(x);
              dvs <= mag(y);
              rneg <= x[W-1];
            end else begin
              g <= x;
              div_busy <= 1'b1;
              cnt <= '0;
              rem <= '0;
              quo <= mag(d);
              dvs <= mag(x);
              qneg <= d[W-1] ^ x[W-1];
              if (d == '0 || x == '0) err <= 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
            if (!trial[W]) rem <= trial[W-1:0];
            else rem <= rem_sh;
            quo <= {quo[W-2:0], !trial[W]};
            if (cnt == CW'(W - 1)) begin
              div_busy <= 1'b0;
              x <= y;
              y <= rneg ? -W'(trial[W] ? rem_sh : trial[W-1:0])
                        : W'(trial[W] ? rem_sh : trial[W-1:0]);
            end
          end
        end
        rag_pkg::ST_DIVD, rag_pkg::ST_DIVN: begin
          if (err) begin
            cnt <= CW'(W);
            div_busy <= 1'b0;
            if (state == rag_pkg::ST_DIVN) ovalid <= 1'b1;
          end else if (div_busy) begin
            cnt <= cnt + 1'b1;
            if (!trial[W]) rem <= trial[W-1:0];
            else rem <= rem_sh;
            quo <= {quo[W-2:0], !trial[W]};
            if (cnt == CW'(W - 1)) div_busy <= 1'b0;
          end else if (state == rag_pkg::ST_DIVD) begin
            d <= qneg ? -$signed(quo) : $signed(quo);
            if (quo == '0) err <= 1'b1;
            div_busy <= 1'b1;
            cnt <= '0;
            rem <= '0;
            quo <= mag(n);
            qneg <= n[W-1] ^ g[W-1];
          end else begin
            n <= qneg ? -$signed(quo) : $signed(quo);
            ovalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status = err;
  assign res_num = err ? '0 : n[rag_pkg::RES_W-1:0];
  assign res_den = err ? '0 : d[rag_pkg::RES_W-1:0];

  `RAG_ASSERT(a_out_state, clk, rst, ovalid |-> (state == rag_pkg::ST_OUT))
  `RAG_ASSERT(a_hold, clk, rst, (ovalid && stall) |=> (ovalid && $stable(res_num)))
  `RAG_ASSERT(a_cnt, clk, rst, div_busy |-> (cnt < CW'(W)))
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for rational_arith_gcd_reduce: directed corner cases, then
// random fraction arithmetic under several sender and receiver idling mixes.
// Depends on rag_pkg and the block RTL only.
`timescale 1ns / 1ps
module tb_top;
  localparam int W = 16;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  typedef struct {
    logic signed [32:0] num;
    logic signed [32:0] den;
    logic               status;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = rag_pkg::OP_ADD;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [32:0] res_num, res_den;
  logic status;

  frac_res_t reduced_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err_status = 0;
  longint cycles = 0;

  rational_arith_gcd_reduce #(.OPERAND_WIDTH(W)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .status(status)
  );

  always #5 clk = ~clk;

  function automatic longint euclid_gcd(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_frac(rag_pkg::op_t op, longint an, longint ad,
                                            longint bn, longint bd);
    frac_res_t r;
    longint n, d, g;
    r.num = '0;
    r.den = '0;
    r.status = 1'b1;
    if (ad == 0 || bd == 0) return r;
    if (op == rag_pkg::OP_ADD || op == rag_pkg::OP_SUB) begin
      if (ad != bd) begin
        d = ad * bd;
        n = (op == rag_pkg::OP_SUB) ? an * bd - bn * ad : an * bd + bn * ad;
      end else begin
        d = ad;
        n = (op == rag_pkg::OP_SUB) ? an - bn : an + bn;
      end
      g = euclid_gcd(d, n);
    end else begin
      if (op == rag_pkg::OP_MUL) begin
        n = an * bn;
        d = ad * bd;
      end else begin
        n = an * bd;
        d = ad * bn;
      end
      g = euclid_gcd(n, d);
    end
    if (d == 0 || g == 0) return r;
    d = d / g;
    n = n / g;
    if (d == 0) return r;
    r.num = n[32:0];
    r.den = d[32:0];
    r.status = 1'b0;
    return r;
  endfunction

  task automatic send_frac(rag_pkg::op_t op, int an, int ad, int bn, int bd);
    logic signed [W-1:0] an_w, ad_w, bn_w, bd_w;
    an_w = W'(an);
    ad_w = W'(ad);
    bn_w = W'(bn);
    bd_w = W'(bd);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode <= op;
    a_num <= an_w;
    a_den <= ad_w;
    b_num <= bn_w;
    b_den <= bd_w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reduced_q.push_back(reduce_frac(op, longint'(an_w), longint'(ad_w),
                                    longint'(bn_w), longint'(bd_w)));
    n_sent++;
  endtask

  function automatic int rand_operand();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 15)) - 8;
      1: return (int'($urandom_range(0, 255)) - 128) * 12;
      default: return int'($urandom_range(0, (1 << W) - 1)) - (1 << (W - 1));
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = (1 << (W - 1)) - 1;
    mn = -(1 << (W - 1));
    idle_pct = 0;
    stall_pct = 0;
    send_frac(rag_pkg::OP_ADD, 1, 2, 1, 3);
    send_frac(rag_pkg::OP_SUB, 3, 4, 1, 4);
    send_frac(rag_pkg::OP_MUL, 2, 3, 9, 4);
    send_frac(rag_pkg::OP_DIV, 2, 3, 4, 9);
    send_frac(rag_pkg::OP_ADD, 5, 0, 1, 2);
    send_frac(rag_pkg::OP_MUL, 1, 2, 7, 0);
    send_frac(rag_pkg::OP_DIV, 3, 5, 0, 7);
    send_frac(rag_pkg::OP_SUB, 4, 6, 4, 6);
    send_frac(rag_pkg::OP_ADD, -3, 7, 3, 7);
    send_frac(rag_pkg::OP_ADD, mx, mx, mx, mn);
    send_frac(rag_pkg::OP_SUB, mn, mn, mx, mx);
    send_frac(rag_pkg::OP_MUL, mn, mx, mn, mx);
    send_frac(rag_pkg::OP_DIV, mn, mn, mn, mx);
    send_frac(rag_pkg::OP_MUL, mn, -1, mn, -1);
    send_frac(rag_pkg::OP_DIV, mx, -1, -1, mn);
    send_frac(rag_pkg::OP_ADD, -1, -1, -1, -1);
    send_frac(rag_pkg::OP_SUB, 0, -5, 0, 3);
    send_frac(rag_pkg::OP_MUL, 0, 3, -6, -9);
    send_frac(rag_pkg::OP_DIV, -6, 4, 9, -2);
    send_frac(rag_pkg::OP_ADD, mx, 1, mx, 1);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    int an, ad, bn, bd;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      an = rand_operand();
      ad = rand_operand();
      bn = rand_operand();
      bd = ($urandom_range(0, 5) == 0) ? ad : rand_operand();
      if ($urandom_range(0, 19) == 0) ad = 0;
      send_frac(rag_pkg::op_t'($urandom_range(0, 3)), an, ad, bn, bd);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_pause_until_empty();
    test_random(10, 0, 0);
    wait_drained();
    test_random(10, 0, 30);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result num=%0d den=%0d st=%0b",
                                       res_num, res_den, status);
      end else begin
        e = reduced_q.pop_front();
        n_checked++;
        if (e.status) n_err_status++;
        if (res_num !== e.num || res_den !== e.den || status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st=%0b got %0d/%0d st=%0b",
                     e.num, e.den, e.status, res_num, res_den, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 62, 0);
    test_pause_until_empty();
    test_random(230, 0, 62);
    test_random(250, 35, 35);
    wait_drained();
    repeat (400) @(posedge clk);
    if (reduced_q.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", reduced_q.size());
    end
    $display("sent %0d transactions, checked %0d results (%0d error status)",
             n_sent, n_checked, n_err_status);
    $display("all four operations, zero denominators and idle/stall mixes covered");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
